// ===== hw/rtl/tatc_pkg.sv =====
// Shared types, breakpoint tables and limits for the thermistor-to-temperature block.
package tatc_pkg;

    localparam int RAW_W    = 12;
    localparam int SEG_W    = 4;
    localparam int NUM_BP   = 13;
    localparam int CENTI_W  = 15;
    localparam int DEN_W    = 10;
    localparam int DT_W     = 12;
    localparam int RECIP_W  = 16;
    localparam int RECIP_SH = 21;
    localparam int QUO_W    = 12;
    localparam int MAG_W    = 21;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W   = $clog2(QUEUE_DEPTH);

    localparam logic signed [15:0] CENTI_MIN = -16'sd6000;
    localparam logic signed [15:0] CENTI_MAX = 16'sd16000;

    // Breakpoint raw codes, sorted rising (33k pullup, 4095 full scale).
    localparam logic [RAW_W-1:0] BP_RAW [NUM_BP] = '{
        12'd347,  12'd591,  12'd885,  12'd1010, 12'd1659, 12'd2061, 12'd2484,
        12'd3079, 12'd3536, 12'd3746, 12'd3889, 12'd4033, 12'd4080
    };

    typedef struct packed {
        logic [RAW_W-1:0] raw;
        logic [SEG_W-1:0] seg;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Raw code at the lower end of a segment.
    function automatic logic [RAW_W-1:0] seg_lo_raw(input logic [SEG_W-1:0] seg);
        logic [RAW_W-1:0] v;
        v = BP_RAW[0];
        for (int i = 0; i < NUM_BP - 1; i++) begin
            if (seg == SEG_W'(i)) begin
                v = BP_RAW[i];
            end
        end
        return v;
    endfunction

    // Temperature at the lower end of a segment, in hundredths.
    function automatic logic signed [CENTI_W-1:0] seg_lo_centi(input logic [SEG_W-1:0] seg);
        logic signed [CENTI_W-1:0] v;
        case (seg)
            4'd0:    v = 15'sd12000;
            4'd1:    v = 15'sd10000;
            4'd2:    v = 15'sd8500;
            4'd3:    v = 15'sd8000;
            4'd4:    v = 15'sd6000;
            4'd5:    v = 15'sd5000;
            4'd6:    v = 15'sd4000;
            4'd7:    v = 15'sd2500;
            4'd8:    v = 15'sd1000;
            4'd9:    v = 15'sd0;
            4'd10:   v = -15'sd1000;
            4'd11:   v = -15'sd3000;
            default: v = 15'sd0;
        endcase
        return v;
    endfunction

    // Temperature step across a segment, in hundredths.
    function automatic logic signed [DT_W-1:0] seg_dt(input logic [SEG_W-1:0] seg);
        logic signed [DT_W-1:0] v;
        case (seg)
            4'd0:    v = -12'sd2000;
            4'd1:    v = -12'sd1500;
            4'd2:    v = -12'sd500;
            4'd3:    v = -12'sd2000;
            4'd4:    v = -12'sd1000;
            4'd5:    v = -12'sd1000;
            4'd6:    v = -12'sd1500;
            4'd7:    v = -12'sd1500;
            4'd8:    v = -12'sd1000;
            4'd9:    v = -12'sd1000;
            4'd10:   v = -12'sd2000;
            4'd11:   v = -12'sd2000;
            default: v = 12'sd0;
        endcase
        return v;
    endfunction

    // Raw width of a segment.
    function automatic logic [DEN_W-1:0] seg_den(input logic [SEG_W-1:0] seg);
        logic [DEN_W-1:0] v;
        case (seg)
            4'd0:    v = 10'd244;
            4'd1:    v = 10'd294;
            4'd2:    v = 10'd125;
            4'd3:    v = 10'd649;
            4'd4:    v = 10'd402;
            4'd5:    v = 10'd423;
            4'd6:    v = 10'd595;
            4'd7:    v = 10'd457;
            4'd8:    v = 10'd210;
            4'd9:    v = 10'd143;
            4'd10:   v = 10'd144;
            4'd11:   v = 10'd47;
            default: v = 10'd1;
        endcase
        return v;
    endfunction

    // floor(2^21 / width): quotient estimate is low by at most one.
    function automatic logic [RECIP_W-1:0] seg_recip(input logic [SEG_W-1:0] seg);
        logic [RECIP_W-1:0] v;
        case (seg)
            4'd0:    v = 16'd8594;
            4'd1:    v = 16'd7133;
            4'd2:    v = 16'd16777;
            4'd3:    v = 16'd3231;
            4'd4:    v = 16'd5216;
            4'd5:    v = 16'd4957;
            4'd6:    v = 16'd3524;
            4'd7:    v = 16'd4588;
            4'd8:    v = 16'd9986;
            4'd9:    v = 16'd14665;
            4'd10:   v = 16'd14563;
            4'd11:   v = 16'd44620;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/tatc_front.sv =====
// Input side: accept a reading, pick its segment, push it to the queue.
module tatc_front (
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [tatc_pkg::RAW_W-1:0]   raw_sample,
    input  tatc_pkg::q_status_t          q_status,
    output logic                         push,
    output tatc_pkg::item_t              push_item
);

    logic [tatc_pkg::SEG_W-1:0] seg;

    // Count interior breakpoints below the reading; the table is sorted.
    always_comb begin
        seg = '0;
        for (int i = 1; i <= tatc_pkg::NUM_BP - 2; i++) begin
            if (raw_sample > tatc_pkg::BP_RAW[i]) begin
                seg = tatc_pkg::SEG_W'(i);
            end
        end
    end

    assign s_tready      = !q_status.full;
    assign push          = s_tvalid && !q_status.full;
    assign push_item.raw = raw_sample;
    assign push_item.seg = seg;

endmodule

// ===== hw/rtl/tatc_queue.sv =====
// Small FIFO between the classifier and the arithmetic pipeline.
module tatc_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  tatc_pkg::item_t      push_item,
    input  logic                 pop,
    output tatc_pkg::item_t      pop_item,
    output tatc_pkg::q_status_t  q_status
);

    localparam int CNT_W = $clog2(tatc_pkg::QUEUE_DEPTH + 1);

    tatc_pkg::item_t                 mem_reg [tatc_pkg::QUEUE_DEPTH];
    logic [tatc_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [tatc_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]                count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item       = mem_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == CNT_W'(tatc_pkg::QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);

endmodule

// ===== hw/rtl/tatc_back.sv =====
// Arithmetic pipeline: interpolate within the segment, round, saturate.
module tatc_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tatc_pkg::q_status_t           q_status,
    input  tatc_pkg::item_t               pop_item,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tatc_pkg::CENTI_W-1:0]  temp_centi
);

    localparam int N_W = tatc_pkg::MAG_W + 1;
    localparam int P_W = tatc_pkg::MAG_W + tatc_pkg::RECIP_W;
    localparam int D_W = tatc_pkg::RAW_W + 1;
    localparam int Q_W = tatc_pkg::QUO_W + 1;

    logic advance;

    logic                          v1_reg, v2_reg, v3_reg, v4_reg;
    // stage 1: signed numerator offset*step
    logic signed [N_W-1:0]         n1_reg, n1_next;
    logic [tatc_pkg::SEG_W-1:0]    seg1_reg, seg2_reg, seg3_reg;
    // stage 2: magnitude and quotient estimate
    logic [tatc_pkg::MAG_W-1:0]    m2_reg, m2_next;
    logic                          neg2_reg;
    logic [tatc_pkg::QUO_W-1:0]    q2_reg, q2_next;
    // stage 3: floor quotient and remainder
    logic signed [Q_W-1:0]         q3_reg, q3_next;
    logic [tatc_pkg::DEN_W-1:0]    r3_reg, r3_next;
    // stage 4: result
    logic [tatc_pkg::CENTI_W-1:0]  temp_reg, temp_next;

    logic signed [D_W-1:0]                    d1;
    logic signed [D_W+tatc_pkg::DT_W-1:0]     prod1;
    logic signed [N_W-1:0]                    n1_neg;
    logic [P_W-1:0]                           prod2;
    logic [tatc_pkg::DEN_W-1:0]               den3, den4;
    logic [N_W-1:0]                           qd3, r0, r0_sub;
    logic                                     ge3;
    logic [tatc_pkg::QUO_W-1:0]               q3u;
    logic [tatc_pkg::DEN_W-1:0]               r3u;
    logic signed [Q_W-1:0]                    q3s;
    logic signed [15:0]                       base4, res4;
    logic [tatc_pkg::DEN_W:0]                 twice_r4;
    logic                                     up4;

    assign advance = !v4_reg || m_tready;
    assign pop     = advance && !q_status.empty;

    // stage 1
    always_comb begin
        d1 = $signed({1'b0, pop_item.raw}) - $signed({1'b0, tatc_pkg::seg_lo_raw(pop_item.seg)});
        prod1 = d1 * tatc_pkg::seg_dt(pop_item.seg);
        n1_next = $signed(prod1[N_W-1:0]);
    end

    // stage 2
    always_comb begin
        n1_neg  = -n1_reg;
        m2_next = n1_reg[N_W-1] ? n1_neg[tatc_pkg::MAG_W-1:0] : n1_reg[tatc_pkg::MAG_W-1:0];
        prod2   = m2_next * tatc_pkg::seg_recip(seg1_reg);
        q2_next = prod2[tatc_pkg::RECIP_SH +: tatc_pkg::QUO_W];
    end

    // stage 3: fix the estimate, then take floor toward minus infinity
    always_comb begin
        den3   = tatc_pkg::seg_den(seg2_reg);
        qd3    = N_W'(q2_reg) * N_W'(den3);
        r0     = {1'b0, m2_reg} - qd3;
        r0_sub = r0 - N_W'(den3);
        ge3    = (r0 >= N_W'(den3));
        q3u    = ge3 ? q2_reg + 1'b1 : q2_reg;
        r3u    = ge3 ? r0_sub[tatc_pkg::DEN_W-1:0] : r0[tatc_pkg::DEN_W-1:0];
        q3s    = $signed({1'b0, q3u});
        q3_next = q3s;
        r3_next = r3u;
        if (neg2_reg) begin
            if (r3u == '0) begin
                q3_next = -q3s;
            end else begin
                q3_next = -q3s - Q_W'(1);
                r3_next = den3 - r3u;
            end
        end
    end

    // stage 4: round half away from zero, then clamp
    always_comb begin
        den4     = tatc_pkg::seg_den(seg3_reg);
        base4    = 16'(tatc_pkg::seg_lo_centi(seg3_reg)) + 16'(q3_reg);
        twice_r4 = {r3_reg, 1'b0};
        up4      = (twice_r4 > {1'b0, den4}) ||
                   ((twice_r4 == {1'b0, den4}) && !base4[15]);
        res4     = up4 ? base4 + 16'sd1 : base4;
        if (res4 < tatc_pkg::CENTI_MIN) begin
            temp_next = tatc_pkg::CENTI_MIN[tatc_pkg::CENTI_W-1:0];
        end else if (res4 > tatc_pkg::CENTI_MAX) begin
            temp_next = tatc_pkg::CENTI_MAX[tatc_pkg::CENTI_W-1:0];
        end else begin
            temp_next = res4[tatc_pkg::CENTI_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= pop;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Hold all stages while the output waits.
    always_ff @(posedge aclk) begin
        if (advance) begin
            n1_reg   <= n1_next;
            seg1_reg <= pop_item.seg;
            m2_reg   <= m2_next;
            neg2_reg <= n1_reg[N_W-1];
            q2_reg   <= q2_next;
            seg2_reg <= seg1_reg;
            q3_reg   <= q3_next;
            r3_reg   <= r3_next;
            seg3_reg <= seg2_reg;
            temp_reg <= temp_next;
        end
    end

    assign m_tvalid   = v4_reg;
    assign temp_centi = temp_reg;

endmodule

// ===== hw/rtl/thermistor_adc_to_temperature.sv =====
// Top level: thermistor ADC reading to temperature in hundredths of a degree.
//
//   channel  direction  tdata bits (low first)          meaning
//   s_       in         [11:0] raw_sample, [15:12] zero  ADC reading
//   m_       out        [14:0] temp_centi, [15] zero     temperature, signed
//
// One reading per cycle sustained while m_tready stays high; the queue slot is
// read straight into the first of the four interpolate/divide stages (offset
// multiply, reciprocal multiply, correction, round and clamp), and the last
// stage registers the result that drives the output.
// Reset clears the queue pointers and count and the pipeline valid bits; no sweep.
// m_tready low while m_tvalid is high freezes the back pipeline; the four-entry
// queue then fills and s_tready drops.
module thermistor_adc_to_temperature (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] raw_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [14:0] temp_centi
);

    tatc_pkg::q_status_t              q_status;
    tatc_pkg::item_t                  push_item;
    tatc_pkg::item_t                  pop_item;
    logic                             push;
    logic                             pop;
    logic [tatc_pkg::CENTI_W-1:0]     temp_centi;

    tatc_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .raw_sample (s_tdata[tatc_pkg::RAW_W-1:0]),
        .q_status   (q_status),
        .push       (push),
        .push_item  (push_item)
    );

    tatc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .pop_item   (pop_item),
        .q_status   (q_status)
    );

    tatc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_status   (q_status),
        .pop_item   (pop_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .temp_centi (temp_centi)
    );

    assign m_tdata = {1'b0, temp_centi};

endmodule
